// ----- hdl/wsr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wsr_pkg;

    localparam int unsigned CODE_W     = 8;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned THR_W      = 8;
    localparam int unsigned LAST_W     = 3;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    typedef logic [CODE_W-1:0]     t_code;
    typedef logic [TIME_W-1:0]     t_time;
    typedef logic [THR_W-1:0]      t_thr;
    typedef logic [LAST_W-1:0]     t_last;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx REG_WINDOW_LENGTH      = 8'd0;
    localparam t_cfg_idx REG_BUSINESS_THRESHOLD = 8'd1;

    localparam t_code CODE_IDLE          = 8'd0;
    localparam t_code CODE_BUSINESS_MIN  = 8'd1;
    localparam t_code CODE_BUSINESS_MAX  = 8'd4;
    localparam t_code CODE_THRESHOLD_HIT = 8'd5;
    localparam t_code CODE_PASS_MIN      = 8'd6;

    localparam t_thr  HITS_MAX            = 8'hFF;
    localparam t_time WINDOW_LENGTH_RESET = 32'd1000;
    localparam t_thr  THRESHOLD_RESET     = 8'd3;

endpackage

`default_nettype wire

// ----- hdl/wsr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface wsr_in_if;
    logic            valid;
    logic            ready;
    wsr_pkg::t_code  status_code;
    wsr_pkg::t_time  now_ms;

    modport source (output valid, output status_code, output now_ms, input ready);
    modport sink   (input valid, input status_code, input now_ms, output ready);
endinterface

interface wsr_out_if;
    logic            valid;
    logic            ready;
    wsr_pkg::t_code  reduced_code;

    modport source (output valid, output reduced_code, input ready);
    modport sink   (input valid, input reduced_code, output ready);
endinterface

interface wsr_cfg_if;
    logic                valid;
    logic                ready;
    wsr_pkg::t_cfg_idx   reg_index;
    wsr_pkg::t_cfg_data  data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/windowed_state_reducer_unit.sv -----
// Items pass the input register, then the output register. Throughput: one item
// per cycle unless the output stalls, set by the single compare-and-update step
// on the window state; an input register holds one more item while a result waits.
// Reset (synchronous, active low) closes the window, empties both stages, and
// restores the window length to 1000 ms and the business threshold to 3.
`timescale 1ns / 1ps
`default_nettype none

module windowed_state_reducer_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    wsr_in_if.sink      i_in,
    wsr_out_if.source   o_out,
    wsr_cfg_if.sink     i_cfg
);

    wsr_pkg::t_time r_window_length;
    wsr_pkg::t_thr  r_threshold;

    logic           r_in_valid;
    wsr_pkg::t_code r_in_code;
    wsr_pkg::t_time r_in_now;

    logic           r_open;
    wsr_pkg::t_time r_start;
    wsr_pkg::t_thr  r_hits;
    logic           r_seen;
    wsr_pkg::t_last r_last;

    logic           r_out_valid;
    wsr_pkg::t_code r_out_code;

    logic           n_open;
    wsr_pkg::t_time n_start;
    wsr_pkg::t_thr  n_hits;
    logic           n_seen;
    wsr_pkg::t_last n_last;
    wsr_pkg::t_code n_out_code;

    logic           proc;
    wsr_pkg::t_time elapsed;
    logic           expired;
    logic           business;
    wsr_pkg::t_code folded;

    assign proc        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || proc;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid        = r_out_valid;
    assign o_out.reduced_code = r_out_code;

    assign elapsed  = r_in_now - r_start;
    assign expired  = r_open && (elapsed >= r_window_length);
    assign business = r_in_code inside {[wsr_pkg::CODE_BUSINESS_MIN:wsr_pkg::CODE_BUSINESS_MAX]};
    assign folded   = r_seen ? {{(wsr_pkg::CODE_W - wsr_pkg::LAST_W){1'b0}}, r_last}
                             : wsr_pkg::CODE_IDLE;

    always_comb begin
        n_open     = r_open;
        n_start    = r_start;
        n_hits     = r_hits;
        n_seen     = r_seen;
        n_last     = r_last;
        n_out_code = wsr_pkg::CODE_IDLE;
        if (r_in_code >= wsr_pkg::CODE_PASS_MIN) begin
            n_open     = 1'b0;
            n_start    = '0;
            n_hits     = '0;
            n_seen     = 1'b0;
            n_last     = '0;
            n_out_code = r_in_code;
        end else if (expired) begin
            n_open     = 1'b0;
            n_start    = '0;
            n_hits     = '0;
            n_seen     = 1'b0;
            n_last     = '0;
            n_out_code = (r_in_code != wsr_pkg::CODE_IDLE) ? r_in_code : folded;
        end else begin
            if (!r_open) begin
                n_open  = 1'b1;
                n_start = r_in_now;
            end
            if (business) begin
                if (r_hits != wsr_pkg::HITS_MAX) begin
                    n_hits = r_hits + 1'b1;
                end
                n_seen = 1'b1;
                n_last = r_in_code[wsr_pkg::LAST_W-1:0];
            end
            if (n_hits >= r_threshold) begin
                n_open     = 1'b0;
                n_start    = '0;
                n_hits     = '0;
                n_seen     = 1'b0;
                n_last     = '0;
                n_out_code = wsr_pkg::CODE_THRESHOLD_HIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= wsr_pkg::WINDOW_LENGTH_RESET;
            r_threshold     <= wsr_pkg::THRESHOLD_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                wsr_pkg::REG_WINDOW_LENGTH: begin
                    r_window_length <= i_cfg.data[wsr_pkg::TIME_W-1:0];
                end
                wsr_pkg::REG_BUSINESS_THRESHOLD: begin
                    r_threshold <= i_cfg.data[wsr_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_code <= i_in.status_code;
            r_in_now  <= i_in.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_start <= '0;
            r_hits  <= '0;
            r_seen  <= 1'b0;
            r_last  <= '0;
        end else if (proc) begin
            r_open  <= n_open;
            r_start <= n_start;
            r_hits  <= n_hits;
            r_seen  <= n_seen;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_code <= n_out_code;
        end
    end

    a_closed_window_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> (r_hits == '0) && !r_seen)
        else $error("closed window holds business state");

    a_seen_matches_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen == (r_last != '0))
        else $error("seen flag and last business code disagree");

    a_pass_through_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && (r_in_code >= wsr_pkg::CODE_PASS_MIN) |=> !r_open)
        else $error("pass-through item left the window open");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> r_out_valid && (r_out_code == $past(n_out_code)))
        else $error("processed item did not reach the output register");

endmodule

`default_nettype wire
